>>> rtl/afs_pkg.sv
`default_nettype none
package afs_pkg;
	// default scale of the result
	localparam int FRAC_BITS_DEF = 12;
	// quotient bits below the overflow test, one cell each
	localparam int NCELL = 31;
	// stages ahead of the cell row
	localparam int NFRONT = 3;
	localparam logic [30:0] ACC_MAX = 31'h7FFF_FFFF;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	// one item on its way down the cell row
	typedef struct packed {
		logic [63:0] r;
		logic [30:0] ylo;
		logic [63:0] d;
		logic [30:0] q;
		status_t     st;
	} afs_item_t;
endpackage
`default_nettype wire

>>> rtl/afs_front.sv
`default_nettype none
module afs_front import afs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic [2:0]         en,
	input  wire logic signed [31:0] speed,
	input  wire logic signed [31:0] end_speed,
	input  wire logic signed [63:0] distance,
	output afs_item_t               item
);
	localparam int YW = 63 + FRAC_BITS;

	logic [32:0] dif, sm, dif_mag, sm_mag;
	logic [63:0] dmag;
	logic [32:0] a_s1, b_s1;
	logic [63:0] d_s1, d_s2;
	logic        zero_s1, zero_s2;
	logic [65:0] prod;
	logic [62:0] prod_s2;
	logic [YW:0] ysh;
	logic [YW-1:0] y;
	logic [63:0] hi;
	logic        ovf;
	afs_item_t   nxt;

	// stage 1: widened difference, sum and distance magnitude
	always_comb begin
		dif = {speed[31], speed} - {end_speed[31], end_speed};
		sm = {speed[31], speed} + {end_speed[31], end_speed};
		dif_mag = dif[32] ? (33'd0 - dif) : dif;
		sm_mag = sm[32] ? (33'd0 - sm) : sm;
		dmag = distance[63] ? (64'd0 - distance) : distance;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1 <= dif_mag;
			b_s1 <= sm_mag;
			d_s1 <= dmag;
			zero_s1 <= (dmag == 64'd0);
		end
	end

	// stage 2: |v^2 - ve^2|, never above 2^62
	assign prod = {33'd0, a_s1} * {33'd0, b_s1};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s2 <= prod[62:0];
			d_s2 <= d_s1;
			zero_s2 <= zero_s1;
		end
	end

	// stage 3: scale, overflow test on the top quotient bits, first remainder
	always_comb begin
		ysh = (YW + 1)'(prod_s2) << FRAC_BITS;
		y = ysh[YW:1];
		hi = 64'(y[YW-1:31]);
		ovf = (hi >= d_s2);
		nxt.r = hi;
		nxt.ylo = y[30:0];
		nxt.d = d_s2;
		nxt.q = '0;
		if (zero_s2) begin
			nxt.st = ST_ZERO;
		end else if (ovf) begin
			nxt.st = ST_SAT;
		end else begin
			nxt.st = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			item <= nxt;
		end
	end
endmodule
`default_nettype wire

>>> rtl/afs_cell.sv
`default_nettype none
module afs_cell import afs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      en,
	input  wire afs_item_t a,
	output afs_item_t      b
);
	logic [64:0] rr, df;
	logic        ge;
	afs_item_t   nxt;

	// one restoring division step: bring down a bit, try the subtract
	always_comb begin
		rr = {a.r, a.ylo[30]};
		df = rr - {1'b0, a.d};
		ge = ~df[64];
		nxt = a;
		nxt.r = ge ? df[63:0] : rr[63:0];
		nxt.ylo = {a.ylo[29:0], 1'b0};
		nxt.q = {a.q[29:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b <= nxt;
		end
	end
endmodule
`default_nettype wire

>>> rtl/accel_from_speed_change_distance.sv
// Acceleration magnitude from a change of speed over a distance.
// accel = floor(|(v-ve)*(v+ve)| * 2^FRAC_BITS / |2*distance|), saturated.
// Input channel: in_valid/in_ready with speed, end_speed, distance.
// Output channel: out_valid/out_ready with accel and status
// (0 ok, 1 saturated, 2 zero distance; accel is all ones in both latter cases).
// From acceptance to out_valid an item passes three front
// stages (magnitudes, multiply, scale and overflow test) and a row of
// 31 division cells, one quotient bit per cell.
// Throughput: one item per cycle while the receiver does not stall; every stage holds one item.
// When the receiver stalls, the last stage holds its item and each stage
// upstream keeps loading as long as it or a later stage has a free slot,
// so new items are taken until the row is full.
// Reset clears all stage valid flags; the row comes up empty and ready.
`default_nettype none
module accel_from_speed_change_distance import afs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] speed,
	input  wire logic signed [31:0] end_speed,
	input  wire logic signed [63:0] distance,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [30:0]             accel,
	output logic [1:0]              status
);
	localparam int NS = NFRONT + NCELL;

	logic [NS-1:0] vld_q;
	logic [NS:0]   en;
	afs_item_t     stg [NCELL+1];

	// stage load enables: a stage loads when empty or when it empties
	always_comb begin
		en[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = ~vld_q[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	afs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.en        (en[2:0]),
		.speed     (speed),
		.end_speed (end_speed),
		.distance  (distance),
		.item      (stg[0])
	);

	// division cell row
	for (genvar j = 0; j < NCELL; j++) begin : g_cell
		afs_cell u_cell (
			.clk (clk),
			.en  (en[NFRONT+j]),
			.a   (stg[j]),
			.b   (stg[j+1])
		);
	end

	assign in_ready = en[0];
	assign out_valid = vld_q[NS-1];
	assign accel = (stg[NCELL].st != ST_OK) ? ACC_MAX : stg[NCELL].q;
	assign status = stg[NCELL].st;

	a_flag_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> accel == ACC_MAX)
		else $error("flagged item without saturated value");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_SAT) || (status == ST_ZERO))
		else $error("bad status code");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted item lost at first stage");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("ready low with a free output slot");
endmodule
`default_nettype wire

>>> dv/tb_accel_from_speed_change_distance.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_accel_from_speed_change_distance;
	import afs_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [30:0] accel;
		status_t     st;
	} accel_res_t;

	// expected-result store and checker
	class accel_scoreboard;
		accel_res_t pending[$];
		int mismatches;

		// exact acceleration of one item
		function accel_res_t compute(logic signed [31:0] v, logic signed [31:0] ve,
				logic signed [63:0] s);
			logic signed [33:0] dif, sum;
			logic [63:0] dmag;
			logic [127:0] num, quo;
			accel_res_t res;
			dif = 34'(v) - 34'(ve);
			sum = 34'(v) + 34'(ve);
			dmag = s[63] ? (64'd0 - s) : s;
			if (dmag == 0) begin
				res.accel = ACC_MAX;
				res.st = ST_ZERO;
				return res;
			end
			num = 128'(dif[33] ? -dif : dif) * 128'(sum[33] ? -sum : sum);
			num = (num << FRAC) >> 1;
			quo = num / 128'(dmag);
			if (quo > 128'(ACC_MAX)) begin
				res.accel = ACC_MAX;
				res.st = ST_SAT;
			end else begin
				res.accel = quo[30:0];
				res.st = ST_OK;
			end
			return res;
		endfunction

		function void note_item(logic signed [31:0] v, logic signed [31:0] ve,
				logic signed [63:0] s);
			pending.push_back(compute(v, ve, s));
		endfunction

		function void check_result(logic [30:0] a, logic [1:0] st);
			accel_res_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result accel=%0d status=%0d", a, st);
				return;
			end
			exp_r = pending.pop_front();
			if (exp_r.accel !== a || exp_r.st !== st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected accel=%0d status=%0d, got accel=%0d status=%0d",
						exp_r.accel, exp_r.st, a, st);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] speed = '0;
	logic signed [31:0] end_speed = '0;
	logic signed [63:0] distance = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [30:0] accel;
	logic [1:0] status;

	accel_scoreboard sb = new();
	int idle_cycles = 0;
	bit long_hold = 1'b0;
	bit drain_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	accel_from_speed_change_distance u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.speed(speed), .end_speed(end_speed), .distance(distance),
		.out_valid(out_valid), .out_ready(out_ready),
		.accel(accel), .status(status)
	);

	// offer one item, with a random gap ahead of it when gap is set
	task automatic send_item(logic signed [31:0] v, logic signed [31:0] ve,
			logic signed [63:0] s, bit gap);
		int g;
		g = gap ? $urandom_range(0, 6) : 0;
		repeat (g) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		speed <= v;
		end_speed <= ve;
		distance <= s;
		do @(posedge clk); while (!in_ready);
		sb.note_item(v, ve, s);
	endtask

	function automatic logic [31:0] rand_speed();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000);
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
				: 32'h8000_0000 + $urandom_range(0, 3);
			default: return 32'($signed($urandom_range(0, 200000)) - 100000);
		endcase
	endfunction

	function automatic logic [63:0] rand_dist();
		logic [63:0] r;
		int w;
		case ($urandom_range(0, 5))
			0: return {$urandom, $urandom};
			1: return 64'd0;
			2: return $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
				: 64'h7FFF_FFFF_FFFF_FFFF;
			default: begin
				// mostly moderate magnitudes so that results stay in range
				w = $urandom_range(1, 63);
				r = {$urandom, $urandom} & ((64'd1 << w) - 1);
				return $urandom_range(0, 1) ? -r : r;
			end
		endcase
	endfunction

	// stimulus
	initial begin
		logic signed [31:0] v, ve;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, zero distance, saturation, truncation
		send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 64'sd1, 1'b0);
		send_item(32'sh8000_0000, 32'sh8000_0000, 64'sd0, 1'b0);
		send_item(0, 0, 64'sd0, 1'b0);
		send_item(0, 0, 64'sd5, 1'b0);
		send_item(32'sh8000_0000, 0, 64'sh8000_0000_0000_0000, 1'b0);
		send_item(32'sh7FFF_FFFF, 0, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b0);
		send_item(32'sh8000_0000, 32'sh7FFF_FFFF, -64'sd1, 1'b0);
		send_item(3, 1, 64'sd3, 1'b0);
		send_item(-3, 1, -64'sd3, 1'b0);
		send_item(1, 3, 64'sd7, 1'b0);
		send_item(-1, -1, 64'sd1, 1'b0);
		send_item(100, 0, 64'sd1, 1'b0);
		send_item(1000, 0, 64'sd2, 1'b0);
		send_item(32'sh0001_0000, 0, 64'sd1, 1'b0);
		send_item(-1, 0, 64'shFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_item(32'shFFFF_FFFF, 32'h5555_5555, 64'shAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_item(32'sh5555_5555, 32'shAAAA_AAAA, 64'sh5555_5555_5555_5555, 1'b0);
		// back-to-back burst while the receiver holds off
		long_hold <= 1'b1;
		for (int i = 0; i < 60; i++)
			send_item(rand_speed(), rand_speed(), rand_dist(), 1'b0);
		// pause until every expected result is in
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		for (int i = 0; i < 1800; i++) begin
			v = rand_speed();
			ve = rand_speed();
			send_item(v, ve, rand_dist(), (i / 200) % 2 == 0);
		end
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		drain_done = 1'b1;
	end

	// receiver: random stalls, one long hold-off
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				out_ready <= 1'b0;
				repeat (150) @(posedge clk);
			end
			g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			repeat (g) begin
				out_ready <= 1'b0;
				@(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// sample accepted results
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(accel, status);

	// watchdog on acceptance activity, and end of run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (drain_done) begin
			if (sb.mismatches == 0 && sb.pending.size() == 0)
				$display("accel_from_speed_change_distance regression: pass");
			else
				$display("accel_from_speed_change_distance regression: fail");
			$finish;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("accel_from_speed_change_distance regression: fail");
			$finish;
		end
	end
endmodule
`default_nettype wire
